// File: hw/rtl/bitmap_first_fit_allocator_top_defines.svh
// Assertion macros used by the allocator top-level RTL.
// Both sample on the rising clock edge and are disabled while reset is low.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_TOP_DEFINES_SVH

// The property must hold at every edge.
`define BFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bfa_pkg.sv
`default_nettype none

package bfa_pkg;

  // Map geometry. WORD_BITS is a power of two.
  localparam int TOTAL_BITS = 8192;
  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WA_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  // Field widths and stream widths.
  localparam int IDX_W      = 13;
  localparam int ACT_W      = 2;
  localparam int TDATA_W    = ((IDX_W + 7) / 8) * 8;

  // Full-flag search tree: groups of words reduced in the first stage.
  localparam int GRP_SIZE   = 16;
  localparam int GRP_POS_W  = $clog2(GRP_SIZE);
  localparam int NUM_GROUPS = (NUM_WORDS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_IDX_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WA_W-1:0]      word_addr_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_MARK    = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GROUP,
    ST_PICK,
    ST_MODIFY
  } state_e;

  // Outcome of the search for the first word that still has a free entry.
  typedef struct packed {
    logic       found;
    word_addr_t word;
  } scan_res_t;

  // Entries of word w that lie inside the map.
  function automatic word_t valid_mask(input word_addr_t w);
    word_t m;
    for (int b = 0; b < WORD_BITS; b++) begin
      m[b] = ((int'(w) * WORD_BITS + b) < TOTAL_BITS);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bfa_word_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module bfa_word_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bfa_flag_scan.sv
`default_nettype none

// Two-level search for the lowest word whose full flag is clear.
// The first level reduces each group of words into a registered summary;
// the second level picks the lowest group with a free word.
module bfa_flag_scan
  import bfa_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [NUM_WORDS-1:0] full_i,
  output scan_res_t                 res_o
);

  logic [NUM_GROUPS*GRP_SIZE-1:0] flags_pad;
  logic [NUM_GROUPS-1:0]          grp_free_d, grp_free_q;
  logic [GRP_POS_W-1:0]           grp_pos_d [NUM_GROUPS];
  logic [GRP_POS_W-1:0]           grp_pos_q [NUM_GROUPS];
  logic [GRP_IDX_W-1:0]           grp_sel;
  int unsigned                    word_sel;

  // Words past the end of the map count as full.
  always_comb begin
    flags_pad                = '1;
    flags_pad[NUM_WORDS-1:0] = full_i;
  end

  // First level: per-group free summary and lowest free word in the group.
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_free_d[g] = ~&flags_pad[g*GRP_SIZE +: GRP_SIZE];
      grp_pos_d[g]  = '0;
      for (int p = GRP_SIZE - 1; p >= 0; p--) begin
        if (!flags_pad[g*GRP_SIZE + p]) begin
          grp_pos_d[g] = GRP_POS_W'(p);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_free_q <= '0;
    end else begin
      grp_free_q <= grp_free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_pos_q <= grp_pos_d;
  end

  // Second level: lowest group that still has a free word.
  always_comb begin
    grp_sel = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_free_q[g]) begin
        grp_sel = GRP_IDX_W'(g);
      end
    end
    word_sel    = int'(grp_sel) * GRP_SIZE + int'(grp_pos_q[grp_sel]);
    res_o.found = |grp_free_q;
    res_o.word  = WA_W'(word_sel);
  end

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_first_fit_allocator_top.sv
// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   tuser: action[1:0];  tdata: entry_index[12:0], zero pad to 16
// m_axis    out  tuser: found;        tdata: granted_index[12:0], zero pad to 16
//
// Allocate steps through accept, the group stage of the full-flag search,
// the pick state that starts the word read, and the modify state.
// Mark used, release and clear go through accept and modify only.
// Reset clears the full flags and the per-word valid bits at once; no RAM sweep.
// A held result stalls the modify cycle until that beat is taken on the master side.
// Input is taken whenever the sequencer is idle.
`default_nettype none

`include "bitmap_first_fit_allocator_top_defines.svh"

module bitmap_first_fit_allocator_top
  import bfa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [TDATA_W-1:0] s_axis_tdata_i,  // entry_index
  input  wire logic [ACT_W-1:0]   s_axis_tuser_i,  // action
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic      [TDATA_W-1:0] m_axis_tdata_o,  // granted_index
  output logic                    m_axis_tuser_o   // found
);

  state_e               state_q, state_d;
  action_e              act_q, act_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  word_addr_t           word_q, word_d;
  logic                 hit_q, hit_d;
  logic [NUM_WORDS-1:0] full_q, full_d;
  logic [NUM_WORDS-1:0] vld_q, vld_d;
  logic                 rd_vld_q;
  logic                 out_vld_q;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     grant_q, grant_d;

  logic                 s_accept;
  logic                 out_free;
  logic                 out_load;
  logic                 clr_load;
  action_e              in_act;
  logic [IDX_W-1:0]     in_idx;
  word_addr_t           in_word;
  scan_res_t            scan;

  logic                 ram_we, ram_re;
  word_addr_t           ram_raddr;
  word_t                ram_rdata;

  word_t                eff_word, vmask, free_bits, bit_mask, new_word;
  logic [BIT_W-1:0]     free_pos;
  logic                 new_full;
  logic                 in_range;
  int unsigned          grant_wide;

  assign in_act          = action_e'(s_axis_tuser_i);
  assign in_idx          = s_axis_tdata_i[IDX_W-1:0];
  assign in_word         = WA_W'(in_idx >> BIT_W);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign clr_load        = out_load && (act_q == ACT_CLEAR);

  bfa_flag_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .full_i (full_q),
    .res_o  (scan)
  );

  bfa_word_ram #(
    .DEPTH (NUM_WORDS),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (word_q),
    .wdata_i (new_word),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Word modify path. A word never written since reset or clear reads as zero.
  always_comb begin
    eff_word  = rd_vld_q ? ram_rdata : '0;
    vmask     = valid_mask(word_q);
    free_bits = ~eff_word & vmask;
    free_pos  = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        free_pos = BIT_W'(b);
      end
    end
    in_range = (int'(idx_q) < TOTAL_BITS);
    case (act_q)
      ACT_ALLOC:   bit_mask = word_t'(1) << free_pos;
      ACT_MARK,
      ACT_RELEASE: bit_mask = word_t'(1) << idx_q[BIT_W-1:0];
      default:     bit_mask = '0;
    endcase
    if (act_q == ACT_RELEASE) begin
      new_word = eff_word & ~bit_mask;
    end else begin
      new_word = eff_word | bit_mask;
    end
    new_full   = ((new_word & vmask) == vmask);
    grant_wide = int'(word_q) * WORD_BITS + int'(free_pos);
  end

  // Sequencer: next state, RAM control and result.
  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    idx_d     = idx_q;
    word_d    = word_q;
    hit_d     = hit_q;
    full_d    = full_q;
    vld_d     = vld_q;
    found_d   = found_q;
    grant_d   = grant_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = in_word;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          act_d  = in_act;
          idx_d  = in_idx;
          word_d = in_word;
          ram_re = (in_act == ACT_MARK) || (in_act == ACT_RELEASE);
          if (in_act == ACT_ALLOC) begin
            state_d = ST_GROUP;
          end else begin
            state_d = ST_MODIFY;
          end
        end
      end
      ST_GROUP: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        hit_d     = scan.found;
        word_d    = scan.word;
        ram_raddr = scan.word;
        ram_re    = scan.found;
        state_d   = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          found_d  = 1'b0;
          grant_d  = '0;
          case (act_q)
            ACT_ALLOC: begin
              if (hit_q) begin
                ram_we         = 1'b1;
                vld_d[word_q]  = 1'b1;
                full_d[word_q] = new_full;
                found_d        = 1'b1;
                grant_d        = grant_wide[IDX_W-1:0];
              end
            end
            ACT_MARK, ACT_RELEASE: begin
              if (in_range) begin
                ram_we         = 1'b1;
                vld_d[word_q]  = 1'b1;
                full_d[word_q] = new_full;
              end
            end
            default: begin
              vld_d  = '0;
              full_d = '0;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      full_q    <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      full_q  <= full_d;
      vld_q   <= vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Request, read and result payload.
  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    idx_q   <= idx_d;
    word_q  <= word_d;
    hit_q   <= hit_d;
    found_q <= found_d;
    grant_q <= grant_d;
    if (ram_re) begin
      rd_vld_q <= vld_q[ram_raddr];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = found_q;
  assign m_axis_tdata_o  = TDATA_W'(grant_q);

  `BFA_ASSERT(a_ram_rw_excl, !(ram_we && ram_re), "RAM read and write in the same cycle")
  `BFA_ASSERT(a_we_in_modify, !ram_we || (state_q == ST_MODIFY), "RAM write outside modify")
  `BFA_ASSERT(a_grant_not_full, !(out_load && found_d) || !full_q[word_q], "grant from full word")
  `BFA_ASSERT_NEXT(a_clear_all, clr_load, ~|(full_q | vld_q), "clear all left state behind")

endmodule

`default_nettype wire
